// File: rtl/core/sbrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbrq_pkg;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_ELEMENT = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_e;

  // Sentinel for an extract that finds no complete batch: -100.00 degrees.
  localparam logic signed [15:0] EMPTY_SAMPLE = -16'sd10000;

  // Ring bookkeeping request, applied at the clock edge that takes the transaction.
  typedef struct packed {
    logic insert;
    logic extract;
  } ring_cmd_t;

  typedef struct packed {
    logic ins_ok;      // insert would be stored
    logic ready_now;   // complete batch waiting before the request
    logic ready_next;  // complete batch waiting after the request
  } ring_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/sbrq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sbrq_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] sample_value;
  logic        [31:0] time_now;

  modport source (output valid, output opcode, output sample_value, output time_now,
                  input ready);
  modport sink   (input valid, input opcode, input sample_value, input time_now,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/sbrq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sbrq_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  result_kind;
  logic               sample_accepted;
  logic               batch_ready;
  logic signed [15:0] out_sample;
  logic        [5:0]  element_index;
  logic        [31:0] batch_time;
  logic               last_of_run;

  modport source (output valid, output result_kind, output sample_accepted,
                  output batch_ready, output out_sample, output element_index,
                  output batch_time, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input sample_accepted,
                  input batch_ready, input out_sample, input element_index,
                  input batch_time, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sbrq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sbrq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/sbrq_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module sbrq_ring #(
  parameter int unsigned SLOT_COUNT   = 4,
  parameter int unsigned BATCH_LENGTH = 8,
  localparam int unsigned SLOT_W      = $clog2(SLOT_COUNT),
  localparam int unsigned FILL_W      = $clog2(BATCH_LENGTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbrq_pkg::ring_cmd_t  cmd_i,
  output sbrq_pkg::ring_stat_t stat_o,
  output logic [SLOT_W-1:0]    wslot_o,
  output logic [SLOT_W-1:0]    rslot_o,
  output logic [FILL_W-1:0]    fill_o
);
  import sbrq_pkg::*;

  logic [SLOT_W-1:0]     ws_q, ws_d, rs_q, rs_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic                  acc_q, acc_d;
  logic [SLOT_COUNT-1:0] comp_q, comp_d;
  logic                  ins_ok, ready_now, ready_next;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
  endfunction

  always_comb begin
    ws_d      = ws_q;
    rs_d      = rs_q;
    fill_d    = fill_q;
    acc_d     = acc_q;
    comp_d    = comp_q;
    ins_ok    = acc_q && (fill_q < FILL_W'(BATCH_LENGTH));
    ready_now = (ws_q != rs_q) && comp_q[rs_q];

    if (cmd_i.insert && ins_ok) begin
      fill_d = fill_q + 1'b1;
      if (fill_d == FILL_W'(BATCH_LENGTH)) begin
        comp_d[ws_q] = 1'b1;
        if (next_slot(ws_q) != rs_q) begin
          ws_d         = next_slot(ws_q);
          comp_d[ws_d] = 1'b0;
          fill_d       = '0;
        end else begin
          acc_d = 1'b0;
        end
      end
    end

    if (cmd_i.extract && ready_now) begin
      rs_d = next_slot(rs_q);
      if (!acc_q) begin
        // Re-arm: open the slot after the stalled one with an empty batch.
        ws_d         = next_slot(ws_q);
        comp_d[ws_d] = 1'b0;
        fill_d       = '0;
        acc_d        = 1'b1;
      end
    end

    ready_next = (ws_d != rs_d) && comp_d[rs_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q   <= '0;
      rs_q   <= '0;
      fill_q <= '0;
      acc_q  <= 1'b1;
      comp_q <= '0;
    end else begin
      ws_q   <= ws_d;
      rs_q   <= rs_d;
      fill_q <= fill_d;
      acc_q  <= acc_d;
      comp_q <= comp_d;
    end
  end

  assign stat_o.ins_ok     = ins_ok;
  assign stat_o.ready_now  = ready_now;
  assign stat_o.ready_next = ready_next;
  assign wslot_o           = ws_q;
  assign rslot_o           = rs_q;
  assign fill_o            = fill_q;

endmodule

`default_nettype wire

// File: rtl/core/sample_batch_ring_queue.sv
// Insert or empty extract: one result, held in the output register; the next
//   item is taken the cycle after while the result port keeps up.
// Extract of a complete batch: the first element passes the sample memory read register,
//   then the output register; then one per cycle while the result port keeps up.
// Reset (rst_ni low, asynchronous): ring pointers, fill count, complete bits and
//   handshakes clear at once; sample and timestamp memories keep their contents.
`timescale 1ns / 1ps
`default_nettype none

module sample_batch_ring_queue #(
  parameter int unsigned SLOT_COUNT   = 4,
  parameter int unsigned BATCH_LENGTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbrq_in_if.sink    in_i,
  sbrq_out_if.source out_o
);
  import sbrq_pkg::*;

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
  localparam int unsigned FILL_W = $clog2(BATCH_LENGTH + 1);
  localparam int unsigned DEPTH  = SLOT_COUNT * BATCH_LENGTH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_e;

  state_e state_q;

  // Ring bookkeeping
  ring_cmd_t         cmd;
  ring_stat_t        stat;
  logic [SLOT_W-1:0] wslot, rslot;
  logic [FILL_W-1:0] fill;

  // Stream sequencer: k_q counts issued reads, ek_q tags the element in the read register,
  // dv_q marks that register as holding an element not yet moved to the output.
  logic [SLOT_W-1:0] base_q;
  logic [FILL_W-1:0] k_q, ek_q;
  logic              dv_q;
  logic              rdy_q;

  // Output register
  logic               ov_q;
  kind_e              kind_q;
  logic               accepted_q;
  logic               bready_q;
  logic signed [15:0] sample_q;
  logic [5:0]         index_q;
  logic [31:0]        time_q;
  logic               last_q;

  logic               out_free, in_acc, is_ins, is_ext, start, load, issue, last_elem;
  logic               smp_we, tim_we;
  logic [ADDR_W-1:0]  smp_waddr, smp_raddr;
  logic [15:0]        smp_rdata;
  logic [31:0]        tim_rdata;

  // Take a transaction only between items and when the output register can take the result.
  assign out_free   = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_ins     = in_acc && (op_e'(in_i.opcode) == OP_INSERT);
  assign is_ext     = in_acc && (op_e'(in_i.opcode) == OP_EXTRACT);
  assign start      = is_ext && stat.ready_now;

  assign cmd.insert  = is_ins;
  assign cmd.extract = is_ext;

  // Move the buffered element out whenever the output register frees up; issue the next
  // read when the read register is empty or is emptied this cycle.
  assign load      = (state_q == ST_STREAM) && dv_q && out_free;
  assign issue     = (state_q == ST_STREAM) && (k_q < FILL_W'(BATCH_LENGTH)) && (!dv_q || load);
  assign last_elem = (ek_q == FILL_W'(BATCH_LENGTH - 1));

  // Writes happen only on inserts and reads only on extracts or while streaming, so an entry
  // is never read and written in the same cycle.
  assign smp_we    = is_ins && stat.ins_ok;
  assign tim_we    = smp_we && (fill == '0);
  assign smp_waddr = ADDR_W'(ADDR_W'(wslot) * ADDR_W'(BATCH_LENGTH) + ADDR_W'(fill));
  assign smp_raddr = ADDR_W'(ADDR_W'(base_q) * ADDR_W'(BATCH_LENGTH) + ADDR_W'(k_q));

  sbrq_ring #(
    .SLOT_COUNT  (SLOT_COUNT),
    .BATCH_LENGTH(BATCH_LENGTH)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .wslot_o(wslot),
    .rslot_o(rslot),
    .fill_o (fill)
  );

  sbrq_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_sample_ram (
    .clk_i  (clk_i),
    .we_i   (smp_we),
    .waddr_i(smp_waddr),
    .wdata_i(in_i.sample_value),
    .re_i   (issue),
    .raddr_i(smp_raddr),
    .rdata_o(smp_rdata)
  );

  // Timestamp is read once when the extract is taken and held for the whole run.
  sbrq_ram #(
    .WIDTH(32),
    .DEPTH(SLOT_COUNT)
  ) u_time_ram (
    .clk_i  (clk_i),
    .we_i   (tim_we),
    .waddr_i(wslot),
    .wdata_i(in_i.time_now),
    .re_i   (start),
    .raddr_i(rslot),
    .rdata_o(tim_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      base_q     <= '0;
      k_q        <= '0;
      ek_q       <= '0;
      dv_q       <= 1'b0;
      rdy_q      <= 1'b0;
      ov_q       <= 1'b0;
      kind_q     <= KIND_INSERT;
      accepted_q <= 1'b0;
      bready_q   <= 1'b0;
      sample_q   <= '0;
      index_q    <= '0;
      time_q     <= '0;
      last_q     <= 1'b0;
    end else begin
      // Drop the result once taken; a new load below overrides.
      if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (is_ins) begin
            ov_q       <= 1'b1;
            kind_q     <= KIND_INSERT;
            accepted_q <= stat.ins_ok;
            bready_q   <= stat.ready_next;
            sample_q   <= '0;
            index_q    <= stat.ins_ok ? 6'(fill) : 6'd0;
            time_q     <= '0;
            last_q     <= 1'b1;
          end else if (start) begin
            base_q  <= rslot;
            k_q     <= '0;
            dv_q    <= 1'b0;
            rdy_q   <= stat.ready_next;
            state_q <= ST_STREAM;
          end else if (is_ext) begin
            ov_q       <= 1'b1;
            kind_q     <= KIND_EMPTY;
            accepted_q <= 1'b0;
            bready_q   <= 1'b0;
            sample_q   <= EMPTY_SAMPLE;
            index_q    <= '0;
            time_q     <= '0;
            last_q     <= 1'b1;
          end
        end
        ST_STREAM: begin
          if (issue) begin
            k_q  <= k_q + 1'b1;
            ek_q <= k_q;
            dv_q <= 1'b1;
          end else if (load) begin
            dv_q <= 1'b0;
          end
          if (load) begin
            ov_q       <= 1'b1;
            kind_q     <= KIND_ELEMENT;
            accepted_q <= 1'b0;
            bready_q   <= rdy_q;
            sample_q   <= smp_rdata;
            index_q    <= 6'(ek_q);
            time_q     <= tim_rdata;
            last_q     <= last_elem;
            if (last_elem) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid           = ov_q;
  assign out_o.result_kind     = kind_q;
  assign out_o.sample_accepted = accepted_q;
  assign out_o.batch_ready     = bready_q;
  assign out_o.out_sample      = sample_q;
  assign out_o.element_index   = index_q;
  assign out_o.batch_time      = time_q;
  assign out_o.last_of_run     = last_q;

endmodule

`default_nettype wire

// File: rtl/core/sbrq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sbrq_checker #(
  parameter int unsigned BATCH_LENGTH = 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic        [1:0]  result_kind_i,
  input logic               sample_accepted_i,
  input logic signed [15:0] out_sample_i,
  input logic        [5:0]  element_index_i,
  input logic        [31:0] batch_time_i,
  input logic               last_of_run_i
);
  import sbrq_pkg::*;

  // Empty extract carries the sentinel and closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == KIND_EMPTY) |->
      (out_sample_i == EMPTY_SAMPLE) && (batch_time_i == '0) &&
      (element_index_i == '0) && last_of_run_i && !sample_accepted_i)
    else $error("empty extract result malformed");

  // A batch element closes the run exactly at the final position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == KIND_ELEMENT) |->
      (last_of_run_i == (element_index_i == 6'(BATCH_LENGTH - 1))))
    else $error("batch run end does not match element position");

  // No new item while a batch run is still being delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == KIND_ELEMENT) && !last_of_run_i |->
      !in_ready_i)
    else $error("item taken during a batch run");

  // A transaction is taken only when the result port can take its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("item taken while a result is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_sample_i) && $stable(result_kind_i) &&
      $stable(element_index_i))
    else $error("stalled result changed");

endmodule

bind sample_batch_ring_queue sbrq_checker #(
  .BATCH_LENGTH(BATCH_LENGTH)
) u_sbrq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .result_kind_i    (out_o.result_kind),
  .sample_accepted_i(out_o.sample_accepted),
  .out_sample_i     (out_o.out_sample),
  .element_index_i  (out_o.element_index),
  .batch_time_i     (out_o.batch_time),
  .last_of_run_i    (out_o.last_of_run)
);

`default_nettype wire
